>>> hw/rtl/alignment_duplicate_filter_set_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the alignment duplicate filter
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ALIGNMENT_DUPLICATE_FILTER_SET_UNIT_DEFINES_SVH
`define ALIGNMENT_DUPLICATE_FILTER_SET_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ADFS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adfs assertion failed");
// Next-cycle implication, disabled during reset.
`define ADFS_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adfs assertion failed");
`else
`define ADFS_ASSERT_IMP(label, clk, rst, ante, cons)
`define ADFS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/adfs_pkg.sv
// ----------------------------------------------------------------------------
// Alignment duplicate filter package
// Shared types, codes and phase arithmetic.
// ----------------------------------------------------------------------------
package adfs_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int LONG_LIMIT   = 255;
  localparam int PHASE_W      = 34;
  localparam int SLOT_W       = 6;
  localparam int COUNT_OUT_W  = 7;
  localparam int IN_TDATA_W   = 152;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 144;
  localparam int OUT_TUSER_W  = 3;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } adfs_req_t;

  typedef enum logic [2:0] {
    STATUS_KEPT     = 3'd0,
    STATUS_ADDED    = 3'd1,
    STATUS_REPLACED = 3'd2,
    STATUS_FULL     = 3'd3,
    STATUS_READ_OK  = 3'd4,
    STATUS_READ_BAD = 3'd5,
    STATUS_CLEARED  = 3'd6
  } adfs_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_FINISH
  } adfs_state_t;

  // One stored alignment.
  typedef struct packed {
    logic        reverse;
    logic [15:0] query_end;
    logic [15:0] query_begin;
    logic [31:0] ref_end;
    logic [31:0] ref_begin;
    logic [15:0] ref_index;
    logic [15:0] tag;
  } adfs_entry_t;

  // The pending add request with its precomputed phases and span.
  typedef struct packed {
    adfs_entry_t               ent;
    logic signed [PHASE_W-1:0] phase_b;
    logic signed [PHASE_W-1:0] phase_e;
    logic [31:0]               span;
  } adfs_probe_t;

  // Registered result of comparing one stored entry with the request.
  typedef struct packed {
    logic hit;
    logic longer;
  } adfs_match_t;

  // Input tdata layout, lowest field last.
  typedef struct packed {
    logic        pad;
    logic [5:0]  slot_index;
    logic [15:0] aligned_length;
    logic        reverse_strand;
    logic [15:0] query_end;
    logic [15:0] query_begin;
    logic [31:0] ref_end;
    logic [31:0] ref_begin;
    logic [15:0] ref_index;
    logic [15:0] tag;
  } adfs_in_t;

  // Output tdata layout, lowest field last.
  typedef struct packed {
    logic [6:0]  pad;
    logic        out_reverse;
    logic [15:0] out_query_end;
    logic [15:0] out_query_begin;
    logic [31:0] out_ref_end;
    logic [31:0] out_ref_begin;
    logic [15:0] out_ref_index;
    logic [15:0] out_tag;
    logic        long_seen;
    logic [6:0]  entry_count;
  } adfs_out_t;

  // Exact phase value: base plus the reverse-strand offset, or base minus
  // the forward-strand offset.
  function automatic logic signed [PHASE_W-1:0] adfs_phase(
    input logic [31:0] base,
    input logic [15:0] q_fwd,
    input logic [15:0] q_rev,
    input logic        rev
  );
    logic signed [PHASE_W-1:0] a;
    logic signed [PHASE_W-1:0] f;
    logic signed [PHASE_W-1:0] r;
    a = signed'({2'b00, base});
    f = signed'({18'd0, q_fwd});
    r = signed'({18'd0, q_rev});
    return rev ? (a + r) : (a - f);
  endfunction

  // Reference span, modulo 2^32.
  function automatic logic [31:0] adfs_span(input logic [31:0] rb, input logic [31:0] re);
    return re - rb + 32'd1;
  endfunction

endpackage

>>> hw/rtl/adfs_match.sv
// ----------------------------------------------------------------------------
// Entry comparator
// Decides whether one stored entry duplicates the pending request.
// ----------------------------------------------------------------------------
module adfs_match (
  input  logic                 clk,
  input  adfs_pkg::adfs_entry_t entry,
  input  adfs_pkg::adfs_probe_t probe,
  output adfs_pkg::adfs_match_t result
);
  import adfs_pkg::*;

  logic signed [PHASE_W-1:0] entry_pb;
  logic signed [PHASE_W-1:0] entry_pe;
  logic [31:0]               entry_span;
  logic                      ref_eq;
  logic                      same;
  logic                      overlap;
  logic                      hit;

  always_comb begin
    entry_pb   = adfs_phase(entry.ref_begin, entry.query_begin, entry.query_end,
                            entry.reverse);
    entry_pe   = adfs_phase(entry.ref_end, entry.query_end, entry.query_begin,
                            entry.reverse);
    entry_span = adfs_span(entry.ref_begin, entry.ref_end);
    ref_eq     = (entry.ref_index == probe.ent.ref_index);
    same       = (entry.ref_begin == probe.ent.ref_begin) &&
                 (entry.ref_end == probe.ent.ref_end) &&
                 (entry.query_begin == probe.ent.query_begin) &&
                 (entry.query_end == probe.ent.query_end);
    overlap    = !((probe.ent.ref_end < entry.ref_begin) ||
                   (entry.ref_end < probe.ent.ref_begin));
    hit        = ref_eq && (same || (overlap && (entry_pb == probe.phase_b) &&
                                     (entry_pe == probe.phase_e)));
  end

  always_ff @(posedge clk) begin
    result.hit    <= hit;
    result.longer <= (probe.span > entry_span);
  end

endmodule

>>> hw/rtl/alignment_duplicate_filter_set_unit.sv
// Add: the scan issues one read per cycle in slot order; each read passes the memory
//   register and the registered compare, then a decision and a commit step give the
//   result. An empty table needs no read; a duplicate found ends the scan early.
// Valid read: memory read, then commit; clear, out-of-range read, unused type: commit.
// One item at a time; a new item is taken while the last result waits for m_tready.
// Reset (rst, synchronous, active high) empties the table and clears all control state.
// ----------------------------------------------------------------------------
// Alignment duplicate filter set
// Table of alignments held in one synchronous memory, scanned entry by entry
// to detect duplicates, with read, clear and append operations.
// ----------------------------------------------------------------------------
`include "alignment_duplicate_filter_set_unit_defines.svh"

module alignment_duplicate_filter_set_unit #(
  parameter int CAPACITY = adfs_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // tdata from bit 0: tag, ref_index, ref_begin, ref_end, query_begin,
  // query_end, reverse_strand, aligned_length, slot_index, zero fill
  input  logic [adfs_pkg::IN_TDATA_W-1:0]    s_tdata,
  // tuser: req_type
  input  logic [adfs_pkg::IN_TUSER_W-1:0]    s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // tdata from bit 0: entry_count, long_seen, out_tag, out_ref_index,
  // out_ref_begin, out_ref_end, out_query_begin, out_query_end, out_reverse,
  // zero fill
  output logic [adfs_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // tuser: status
  output logic [adfs_pkg::OUT_TUSER_W-1:0]   m_tuser
);
  import adfs_pkg::*;

  // Count register must hold CAPACITY itself; addresses only reach CAPACITY-1.
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMPW = (CW > SLOT_W) ? CW : SLOT_W;

  // The table itself: one entry per slot, one read and one write port.
  adfs_entry_t mem [CAPACITY];
  adfs_entry_t rd_data;

  adfs_state_t  state;
  adfs_state_t  state_next;

  // Request captured at acceptance.
  adfs_probe_t  req_probe;
  adfs_req_t    req_kind;
  logic [5:0]   req_slot;
  logic         req_long;

  // Scan pipeline: address issue, memory read, registered compare.
  logic [CW-1:0] scan_idx;
  logic          v1;
  logic          v2;
  logic [AW-1:0] idx1;
  logic [AW-1:0] idx2;
  adfs_match_t   match_res;

  // Decided action, applied in the commit cycle.
  adfs_status_t  res_status;
  logic          act_write;
  logic [AW-1:0] act_addr;

  logic [CW-1:0] count;
  logic          long_flag;

  adfs_in_t      in_item;
  adfs_probe_t   probe_in;
  logic          in_slot_ok;
  logic [CMPW-1:0] slot_ext;

  logic          accept;
  logic          issue;
  logic          all_issued;
  logic          decide;
  logic          commit;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [CW-1:0] count_next;
  logic          long_next;
  adfs_status_t  dec_status;
  logic          dec_write;
  logic [AW-1:0] dec_addr;
  adfs_out_t     out_next;

  // Unpack the request and precompute its phases and span, so the compare
  // stage only handles the stored side.
  always_comb begin
    in_item                 = adfs_in_t'(s_tdata);
    probe_in.ent.tag         = in_item.tag;
    probe_in.ent.ref_index   = in_item.ref_index;
    probe_in.ent.ref_begin   = in_item.ref_begin;
    probe_in.ent.ref_end     = in_item.ref_end;
    probe_in.ent.query_begin = in_item.query_begin;
    probe_in.ent.query_end   = in_item.query_end;
    probe_in.ent.reverse     = in_item.reverse_strand;
    probe_in.phase_b = adfs_phase(in_item.ref_begin, in_item.query_begin,
                                  in_item.query_end, in_item.reverse_strand);
    probe_in.phase_e = adfs_phase(in_item.ref_end, in_item.query_end,
                                  in_item.query_begin, in_item.reverse_strand);
    probe_in.span    = adfs_span(in_item.ref_begin, in_item.ref_end);
    in_slot_ok       = (CMPW'(in_item.slot_index) < CMPW'(count));
    slot_ext         = CMPW'(req_slot);
  end

  adfs_match u_match (
    .clk    (clk),
    .entry  (rd_data),
    .probe  (req_probe),
    .result (match_res)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          case (adfs_req_t'(s_tuser))
            REQ_ADD:  state_next = S_SCAN;
            REQ_READ: state_next = in_slot_ok ? S_READ : S_FINISH;
            default:  state_next = S_FINISH;
          endcase
        end
      end
      S_SCAN: begin
        if (decide) begin
          state_next = S_FINISH;
        end
      end
      S_READ:   state_next = S_FINISH;
      S_FINISH: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Control outputs and the commit values.
  always_comb begin
    s_tready   = (state == S_IDLE);
    accept     = s_tvalid && s_tready;
    all_issued = (scan_idx >= count);
    // The first hit to come out of the compare stage is the earliest
    // matching entry, because addresses are issued in slot order.
    decide     = (state == S_SCAN) &&
                 ((v2 && match_res.hit) || (all_issued && !v1 && !v2));
    issue      = (state == S_SCAN) && !decide && !all_issued;
    rd_en      = issue || (state == S_READ);
    rd_addr    = (state == S_READ) ? slot_ext[AW-1:0] : scan_idx[AW-1:0];
    commit     = (state == S_FINISH) && (!m_tvalid || m_tready);
    wr_en      = commit && act_write;

    if (v2 && match_res.hit) begin
      dec_status = match_res.longer ? STATUS_REPLACED : STATUS_KEPT;
      dec_write  = match_res.longer;
      dec_addr   = idx2;
    end else if (count < CW'(CAPACITY)) begin
      dec_status = STATUS_ADDED;
      dec_write  = 1'b1;
      dec_addr   = count[AW-1:0];
    end else begin
      dec_status = STATUS_FULL;
      dec_write  = 1'b0;
      dec_addr   = count[AW-1:0];
    end

    count_next = count;
    long_next  = long_flag;
    if (commit) begin
      if (req_kind == REQ_CLEAR) begin
        count_next = '0;
        long_next  = 1'b0;
      end else if (req_kind == REQ_ADD) begin
        long_next = long_flag | req_long;
        if (res_status == STATUS_ADDED) begin
          count_next = count + CW'(1);
        end
      end
    end

    out_next             = '0;
    out_next.entry_count = COUNT_OUT_W'(count_next);
    out_next.long_seen   = long_next;
    if (res_status == STATUS_READ_OK) begin
      out_next.out_tag         = rd_data.tag;
      out_next.out_ref_index   = rd_data.ref_index;
      out_next.out_ref_begin   = rd_data.ref_begin;
      out_next.out_ref_end     = rd_data.ref_end;
      out_next.out_query_begin = rd_data.query_begin;
      out_next.out_query_end   = rd_data.query_end;
      out_next.out_reverse     = rd_data.reverse;
    end
  end

  // Table memory. Writes happen only in the commit cycle, after every read
  // of the same item has finished, so no forwarding path is needed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[act_addr] <= req_probe.ent;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Request capture and decision registers (payload, no reset).
  always_ff @(posedge clk) begin
    if (accept) begin
      req_probe <= probe_in;
      req_kind  <= adfs_req_t'(s_tuser);
      req_slot  <= in_item.slot_index;
      req_long  <= (in_item.query_end > 16'(LONG_LIMIT)) ||
                   (in_item.aligned_length > 16'(LONG_LIMIT));
      act_write <= 1'b0;
      act_addr  <= '0;
      case (adfs_req_t'(s_tuser))
        REQ_ADD:   res_status <= STATUS_KEPT;
        REQ_CLEAR: res_status <= STATUS_CLEARED;
        REQ_READ:  res_status <= in_slot_ok ? STATUS_READ_OK : STATUS_READ_BAD;
        default:   res_status <= STATUS_READ_BAD;
      endcase
    end else if (decide) begin
      res_status <= dec_status;
      act_write  <= dec_write;
      act_addr   <= dec_addr;
    end
    if (issue) begin
      idx1 <= scan_idx[AW-1:0];
    end
    idx2 <= idx1;
    if (commit) begin
      m_tdata <= OUT_TDATA_W'(out_next);
      m_tuser <= OUT_TUSER_W'(res_status);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      long_flag <= 1'b0;
      scan_idx  <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      long_flag <= long_next;
      if (accept) begin
        scan_idx <= '0;
      end else if (issue) begin
        scan_idx <= scan_idx + CW'(1);
      end
      // Reads still in flight after the decision are simply dropped.
      if ((state == S_SCAN) && !decide) begin
        v1 <= issue;
        v2 <= v1;
      end else begin
        v1 <= 1'b0;
        v2 <= 1'b0;
      end
      if (commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  `ADFS_ASSERT_IMP(a_count_cap, clk, rst, 1'b1, count <= CW'(CAPACITY))
  `ADFS_ASSERT_IMP(a_write_commit, clk, rst, wr_en, commit && (state == S_FINISH))
  `ADFS_ASSERT_IMP(a_cmp_in_scan, clk, rst, v2, state == S_SCAN)
  `ADFS_ASSERT_NXT(a_commit_out, clk, rst, commit, m_tvalid)
  `ADFS_ASSERT_NXT(a_clear, clk, rst, commit && (req_kind == REQ_CLEAR), (count == '0) && !long_flag)

endmodule
